FILE: src/cse_pkg.sv
// ----------------------------------------------------------------------------
// Crosslink spring energy package
// Function codes, register indexes, field widths and arithmetic constants
// shared by the energy unit and its square-root engine.
// ----------------------------------------------------------------------------
package cse_pkg;

   typedef enum logic [2:0] {
      FUNC_WRITE = 3'd0,
      FUNC_LINK  = 3'd1,
      FUNC_CLEAR = 3'd2,
      FUNC_DIFF  = 3'd3,
      FUNC_TOTAL = 3'd4
   } func_type;

   localparam logic [7:0] CSR_SPRING = 8'd0;
   localparam logic [7:0] CSR_REST   = 8'd1;

   localparam int CHAIN_W  = 3;
   localparam int SEC_IN_W = 6;
   localparam int COORD_W  = 32;
   localparam int ENERGY_W = 48;

   // Squared distance of three 33-bit differences fits in 68 bits.
   localparam int RAD_W  = 68;
   localparam int ROOT_W = RAD_W / 2;
   localparam int MUL_W  = 34;
   localparam int Q_W    = 100;

   localparam logic [46:0] E_MAX = 47'h7FFF_FFFF_FFFF;

endpackage

FILE: src/cse_isqrt.sv
// ----------------------------------------------------------------------------
// Integer square root engine
// Restoring digit recurrence, one root bit per cycle; gives floor(sqrt(x)).
// ----------------------------------------------------------------------------
module cse_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cse_pkg::RAD_W-1:0]   radicand,
   output logic                        busy,
   output logic                        done,
   output logic [cse_pkg::ROOT_W-1:0]  root
);
   import cse_pkg::*;

   localparam int REM_W = ROOT_W + 3;
   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic              take;

   always_comb begin
      rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
      trial  = REM_W'({root_ff, 2'b01});
      take   = (rem_sh >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= CNT_W'(ROOT_W);
         end else if (busy_ff) begin
            rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
            rem_ff  <= take ? rem_sh - trial : rem_sh;
            root_ff <= {root_ff[ROOT_W-2:0], take};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = root_ff;

endmodule

FILE: src/crosslink_spring_energy_diff_unit.sv
// ----------------------------------------------------------------------------
// Crosslink spring energy difference unit
// Holds bead positions and per-section crosslink tables, and evaluates
// harmonic link energies with one shared multiplier and a square-root engine.
// ----------------------------------------------------------------------------
// The input reopens in the same cycle that the response word is presented.
// The time per link is set by the single memory read port, the shared
// multiplier and the bit-serial root. A difference query walks up to three
// sections twice, so up to about 6*LINKS_PER_SECTION links; a total query
// walks every section once. One word is worked on at a time; the next may be
// accepted while a response waits, and a stalled response then holds that
// word in S_DONE. Reset is synchronous, clears the FSM, the section link
// counts and restores both registers to 1.0.
module crosslink_spring_energy_diff_unit #(
   parameter int CHAINS            = 8,
   parameter int SECTIONS          = 64,
   parameter int DIMENSIONS        = 3,
   parameter int LINKS_PER_SECTION = 8
) (
   input  logic          clock,
   input  logic          reset,
   // tuser: func[2:0]
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [2:0]    req_tuser,
   // tdata: chain[2:0], partner[5:3], section[11:6], x[43:12], y[75:44],
   // z[107:76], zero fill[111:108]
   input  logic [111:0]  req_tdata,
   // tdata: energy[47:0], status[48], zero fill[55:49]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [55:0]   rsp_tdata,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [7:0]    csr_index,
   input  logic [31:0]   csr_data
);
   import cse_pkg::*;

   localparam int POS_DEPTH = CHAINS * SECTIONS * DIMENSIONS;
   localparam int PAW = $clog2(POS_DEPTH);
   localparam int SW  = $clog2(SECTIONS);
   localparam int LAW = $clog2(SECTIONS * LINKS_PER_SECTION);
   localparam int CW  = $clog2(LINKS_PER_SECTION + 1);
   localparam int KW  = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

   typedef enum logic [4:0] {
      S_IDLE, S_WPOS, S_ADD_RD, S_ADD_WR, S_CLR, S_TR_RD, S_TR_WR,
      S_SEC_RD, S_SEC_CHK, S_PAIR_RD, S_PAIR_LD, S_P1_RD, S_P2_RD, S_DIFF,
      S_SQ, S_SACC, S_SQST, S_SQRT, S_ASQ, S_PSAVE, S_MLO, S_MHI, S_QADD,
      S_EADD, S_SEC_NEXT, S_FIN, S_DONE
   } state_type;

   state_type state_ff;

   // Item fields.
   func_type                   func_ff;
   logic [CHAIN_W-1:0]         chain_ff;
   logic [SEC_IN_W-1:0]        sec_ff;
   logic signed [COORD_W-1:0]  v_ff     [DIMENSIONS];
   logic signed [COORD_W-1:0]  trial_ff [DIMENSIONS];

   // Walk counters.
   logic [KW-1:0]              k_ff;
   logic [SW-1:0]              m_ff;
   logic [SW-1:0]              lo_ff;
   logic [SW-1:0]              hi_ff;
   logic [CW-1:0]              b_ff;
   logic [CW-1:0]              cnt_ff;
   logic                       pass_ff;
   logic [CHAIN_W-1:0]         c1_ff;
   logic [CHAIN_W-1:0]         c2_ff;

   // Arithmetic datapath.
   logic signed [COORD_W-1:0]  p1_ff;
   logic [MUL_W-1:0]           ad_ff;
   logic [RAD_W-1:0]           s_ff;
   logic [MUL_W-1:0]           a_ff;
   logic [2*MUL_W-1:0]         p_ff;
   logic [2*MUL_W-1:0]         prod_ff;
   logic [Q_W-1:0]             q_ff;
   logic [46:0]                acc_ff;
   logic [46:0]                before_ff;
   logic [ENERGY_W-1:0]        res_energy_ff;
   logic                       res_status_ff;

   logic [31:0]                spring_ff;
   logic [31:0]                rest_ff;

   logic                       rsp_valid_ff;
   logic [ENERGY_W-1:0]        rsp_energy_ff;
   logic                       rsp_status_ff;

   // Stores.
   logic [COORD_W-1:0]         pos_mem  [POS_DEPTH];
   logic [COORD_W-1:0]         pos_rd_ff;
   logic [2*CHAIN_W-1:0]       pair_mem [SECTIONS*LINKS_PER_SECTION];
   logic [2*CHAIN_W-1:0]       pair_rd_ff;
   logic [CW-1:0]              cnt_mem  [SECTIONS];
   logic [CW-1:0]              cnt_rd_ff;
   logic [SECTIONS-1:0]        cnt_vld_ff;
   logic                       cnt_vld_rd_ff;

   // Input unpacking.
   logic [CHAIN_W-1:0]         in_chain;
   logic [CHAIN_W-1:0]         in_partner;
   logic [SEC_IN_W-1:0]        in_section;
   logic signed [COORD_W-1:0]  coord_in [3];
   logic [SW-1:0]              in_sec_idx;
   logic                       chain_ok;
   logic                       partner_ok;
   logic                       sec_ok;
   logic                       req_accept;

   logic [SW-1:0]              sec_idx;
   logic [PAW-1:0]             pos_addr;
   logic [SW-1:0]              cnt_addr;
   logic [LAW-1:0]             pair_wr_addr;
   logic [LAW-1:0]             pair_rd_addr;
   logic [CW-1:0]              cnt_eff;
   logic                       sect_full;
   logic                       last_k;
   logic signed [COORD_W-1:0]  coord1;
   logic signed [COORD_W-1:0]  coord2;
   logic signed [COORD_W:0]    diff;
   logic signed [COORD_W:0]    tsum;
   logic signed [COORD_W-1:0]  tsat;
   logic [MUL_W-1:0]           mul_a;
   logic [MUL_W-1:0]           mul_b;
   logic [46:0]                link_e;
   logic [47:0]                acc_sum;

   logic                       sq_start;
   logic                       sq_busy;
   logic                       sq_done;
   logic [ROOT_W-1:0]          sq_root;

   function automatic logic [PAW-1:0] pos_index(input logic [CHAIN_W-1:0] c,
                                                input logic [SW-1:0] m,
                                                input logic [KW-1:0] k);
      return PAW'((int'(c) * SECTIONS + int'(m)) * DIMENSIONS + int'(k));
   endfunction

   assign in_chain    = req_tdata[2:0];
   assign in_partner  = req_tdata[5:3];
   assign in_section  = req_tdata[11:6];
   assign coord_in[0] = req_tdata[43:12];
   assign coord_in[1] = req_tdata[75:44];
   assign coord_in[2] = req_tdata[107:76];
   assign in_sec_idx  = SW'(in_section);
   assign chain_ok    = (int'(in_chain) < CHAINS);
   assign partner_ok  = (int'(in_partner) < CHAINS);
   assign sec_ok      = (int'(in_section) < SECTIONS);

   assign req_tready  = (state_ff == S_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;

   assign sec_idx      = SW'(sec_ff);
   assign last_k       = (k_ff == KW'(DIMENSIONS - 1));
   assign cnt_eff      = cnt_vld_rd_ff ? cnt_rd_ff : '0;
   assign sect_full    = (cnt_eff >= CW'(LINKS_PER_SECTION));
   assign cnt_addr     = (state_ff == S_ADD_RD || state_ff == S_ADD_WR) ? sec_idx : m_ff;
   assign pair_wr_addr = LAW'(int'(sec_idx) * LINKS_PER_SECTION + int'(cnt_eff));
   assign pair_rd_addr = LAW'(int'(m_ff) * LINKS_PER_SECTION + int'(b_ff));
   assign sq_start     = (state_ff == S_SQST);

   always_comb begin
      case (state_ff)
         S_WPOS, S_TR_RD: pos_addr = pos_index(chain_ff, sec_idx, k_ff);
         S_P2_RD:         pos_addr = pos_index(c2_ff, m_ff, k_ff);
         default:         pos_addr = pos_index(c1_ff, m_ff, k_ff);
      endcase
   end

   // On the second pass the moved bead reads its trial coordinate.
   always_comb begin
      coord1 = (pass_ff && c1_ff == chain_ff && m_ff == sec_idx) ? trial_ff[k_ff] : pos_rd_ff;
      coord2 = (pass_ff && c2_ff == chain_ff && m_ff == sec_idx) ? trial_ff[k_ff] : pos_rd_ff;
      diff   = (COORD_W+1)'(p1_ff) - (COORD_W+1)'(coord2);
      tsum   = (COORD_W+1)'(signed'(pos_rd_ff)) + (COORD_W+1)'(v_ff[k_ff]);
      if (tsum[COORD_W] != tsum[COORD_W-1]) begin
         tsat = tsum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         tsat = tsum[COORD_W-1:0];
      end
   end

   always_comb begin
      case (state_ff)
         S_SQ: begin
            mul_a = ad_ff;
            mul_b = ad_ff;
         end
         S_ASQ: begin
            mul_a = a_ff;
            mul_b = a_ff;
         end
         S_MLO: begin
            mul_a = p_ff[MUL_W-1:0];
            mul_b = MUL_W'(spring_ff);
         end
         S_MHI: begin
            mul_a = p_ff[2*MUL_W-1:MUL_W];
            mul_b = MUL_W'(spring_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      link_e  = (|q_ff[Q_W-1:80]) ? E_MAX : q_ff[79:33];
      acc_sum = {1'b0, acc_ff} + {1'b0, link_e};
   end

   cse_isqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (s_ff),
      .busy     (sq_busy),
      .done     (sq_done),
      .root     (sq_root)
   );

   // Shared multiplier with its product register.
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_WPOS) begin
         pos_mem[pos_addr] <= v_ff[k_ff];
      end
      pos_rd_ff <= pos_mem[pos_addr];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_ADD_WR && !sect_full) begin
         pair_mem[pair_wr_addr] <= {c2_ff, c1_ff};
         cnt_mem[sec_idx]       <= cnt_eff + 1'b1;
      end
      pair_rd_ff    <= pair_mem[pair_rd_addr];
      cnt_rd_ff     <= cnt_mem[cnt_addr];
      cnt_vld_rd_ff <= cnt_vld_ff[cnt_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff <= '0;
      end else if (state_ff == S_CLR) begin
         cnt_vld_ff[sec_idx] <= 1'b0;
      end else if (state_ff == S_ADD_WR && !sect_full) begin
         cnt_vld_ff[sec_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spring_ff <= 32'h0001_0000;
         rest_ff   <= 32'h0001_0000;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_SPRING) begin
            spring_ff <= csr_data;
         end else if (csr_index == CSR_REST) begin
            rest_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  func_ff       <= func_type'(req_tuser);
                  chain_ff      <= in_chain;
                  c1_ff         <= in_chain;
                  c2_ff         <= in_partner;
                  sec_ff        <= in_section;
                  for (int i = 0; i < DIMENSIONS; i++) begin
                     v_ff[i] <= coord_in[i];
                  end
                  k_ff          <= '0;
                  b_ff          <= '0;
                  acc_ff        <= '0;
                  before_ff     <= '0;
                  pass_ff       <= 1'b0;
                  res_energy_ff <= '0;
                  res_status_ff <= 1'b0;
                  if (req_tuser == FUNC_TOTAL) begin
                     lo_ff <= '0;
                     hi_ff <= SW'(SECTIONS - 1);
                     m_ff  <= '0;
                  end else begin
                     lo_ff <= (in_sec_idx == '0) ? '0 : in_sec_idx - 1'b1;
                     m_ff  <= (in_sec_idx == '0) ? '0 : in_sec_idx - 1'b1;
                     hi_ff <= (in_sec_idx == SW'(SECTIONS - 1)) ? in_sec_idx
                                                                : in_sec_idx + 1'b1;
                  end
                  case (req_tuser)
                     FUNC_WRITE: state_ff <= (chain_ok && sec_ok) ? S_WPOS : S_DONE;
                     FUNC_LINK:  state_ff <= (chain_ok && partner_ok && sec_ok) ? S_ADD_RD
                                                                                : S_DONE;
                     FUNC_CLEAR: state_ff <= sec_ok ? S_CLR : S_DONE;
                     FUNC_DIFF:  state_ff <= (chain_ok && sec_ok) ? S_TR_RD : S_DONE;
                     FUNC_TOTAL: state_ff <= S_SEC_RD;
                     default:    state_ff <= S_DONE;
                  endcase
               end
            end
            S_WPOS: begin
               k_ff     <= k_ff + 1'b1;
               state_ff <= last_k ? S_DONE : S_WPOS;
            end
            S_ADD_RD: state_ff <= S_ADD_WR;
            S_ADD_WR: begin
               res_status_ff <= sect_full;
               state_ff      <= S_DONE;
            end
            S_CLR:   state_ff <= S_DONE;
            S_TR_RD: state_ff <= S_TR_WR;
            S_TR_WR: begin
               trial_ff[k_ff] <= tsat;
               if (last_k) begin
                  k_ff     <= '0;
                  state_ff <= S_SEC_RD;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_TR_RD;
               end
            end
            S_SEC_RD: state_ff <= S_SEC_CHK;
            S_SEC_CHK: begin
               cnt_ff   <= cnt_eff;
               b_ff     <= '0;
               state_ff <= (cnt_eff == '0) ? S_SEC_NEXT : S_PAIR_RD;
            end
            S_PAIR_RD: state_ff <= S_PAIR_LD;
            S_PAIR_LD: begin
               c1_ff    <= pair_rd_ff[CHAIN_W-1:0];
               c2_ff    <= pair_rd_ff[2*CHAIN_W-1:CHAIN_W];
               k_ff     <= '0;
               s_ff     <= '0;
               state_ff <= S_P1_RD;
            end
            S_P1_RD: state_ff <= S_P2_RD;
            S_P2_RD: begin
               p1_ff    <= coord1;
               state_ff <= S_DIFF;
            end
            S_DIFF: begin
               ad_ff    <= diff[COORD_W] ? MUL_W'(-diff) : MUL_W'(diff);
               state_ff <= S_SQ;
            end
            S_SQ: state_ff <= S_SACC;
            S_SACC: begin
               s_ff <= s_ff + RAD_W'(prod_ff);
               if (last_k) begin
                  state_ff <= S_SQST;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_P1_RD;
               end
            end
            S_SQST: state_ff <= S_SQRT;
            S_SQRT: begin
               if (sq_done) begin
                  a_ff <= (sq_root >= ROOT_W'(rest_ff)) ? sq_root - ROOT_W'(rest_ff)
                                                        : ROOT_W'(rest_ff) - sq_root;
                  state_ff <= S_ASQ;
               end
            end
            S_ASQ: state_ff <= S_PSAVE;
            S_PSAVE: begin
               p_ff     <= prod_ff;
               state_ff <= S_MLO;
            end
            S_MLO: state_ff <= S_MHI;
            S_MHI: begin
               q_ff     <= Q_W'(prod_ff);
               state_ff <= S_QADD;
            end
            S_QADD: begin
               q_ff     <= q_ff + (Q_W'(prod_ff) << MUL_W);
               state_ff <= S_EADD;
            end
            S_EADD: begin
               acc_ff <= acc_sum[47] ? E_MAX : acc_sum[46:0];
               if (CW'(b_ff + 1'b1) < cnt_ff) begin
                  b_ff     <= b_ff + 1'b1;
                  state_ff <= S_PAIR_RD;
               end else begin
                  state_ff <= S_SEC_NEXT;
               end
            end
            S_SEC_NEXT: begin
               if (m_ff == hi_ff) begin
                  if (func_ff == FUNC_DIFF && !pass_ff) begin
                     before_ff <= acc_ff;
                     acc_ff    <= '0;
                     pass_ff   <= 1'b1;
                     m_ff      <= lo_ff;
                     state_ff  <= S_SEC_RD;
                  end else begin
                     state_ff <= S_FIN;
                  end
               end else begin
                  m_ff     <= m_ff + 1'b1;
                  state_ff <= S_SEC_RD;
               end
            end
            S_FIN: begin
               if (func_ff == FUNC_DIFF) begin
                  res_energy_ff <= {1'b0, acc_ff} - {1'b0, before_ff};
               end else begin
                  res_energy_ff <= {1'b0, acc_ff};
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_energy_ff <= res_energy_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_status_ff, rsp_energy_ff};

`ifndef SYNTHESIS
   // The root engine only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset) sq_done |-> state_ff == S_SQRT)
      else $error("square root finished outside its wait state");

   // An accepted word keeps the input side closed on the next cycle.
   assert property (@(posedge clock) disable iff (reset) req_accept |=> !req_tready)
      else $error("input ready straight after an accepted word");

   // A dropped link reports no energy.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && rsp_tdata[48] |-> rsp_tdata[47:0] == '0)
      else $error("full-section status with non-zero energy");

   // The root engine is never started while it is still busy.
   assert property (@(posedge clock) disable iff (reset) sq_start |-> !sq_busy)
      else $error("square root started while busy");
`endif

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Crosslink spring energy unit testbench
// Drives position writes, link adds and clears, difference and total energy
// queries through the request stream. Each response word is checked against a
// fixed-point model of bead store and link tables, or a directed row's value.
// ----------------------------------------------------------------------------
module testbench;
   import cse_pkg::*;

   localparam int NCH  = 8;
   localparam int NSEC = 64;
   localparam int NDIM = 3;
   localparam int NLNK = 8;
   localparam int IDLE_LIMIT = 200000;
   localparam logic [47:0] ENERGY_SAT = {1'b0, E_MAX};

   typedef struct {
      logic [2:0]  func;
      logic [2:0]  chain;
      logic [2:0]  partner;
      logic [5:0]  section;
      logic [31:0] x, y, z;
      bit          fixed;
      logic [47:0] fixed_energy;
      logic        fixed_status;
   } bead_op_type;

   typedef struct {
      logic [47:0] energy;
      logic        status;
   } energy_word_type;

   logic          clock, reset;
   logic          req_tvalid, req_tready;
   logic [2:0]    req_tuser;
   logic [111:0]  req_tdata;
   logic          rsp_tvalid, rsp_tready;
   logic [55:0]   rsp_tdata;
   logic          csr_valid, csr_ready;
   logic [7:0]    csr_index;
   logic [31:0]   csr_data;

   crosslink_spring_energy_diff_unit DUT (.*);

   // Model state
   logic signed [31:0] bead_pos [NCH][NSEC][NDIM];
   bit                 bead_set [NCH][NSEC];
   logic [2:0]         link_a [NSEC][NLNK];
   logic [2:0]         link_b [NSEC][NLNK];
   int unsigned        link_cnt [NSEC];
   logic [31:0]        spring_k, rest_len;

   energy_word_type energy_q[$];
   bead_op_type     cur_op;
   int unsigned     req_taken, csr_taken, idle_cycles;
   bit              failed;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic logic [34:0] root_q(logic [67:0] s);
      logic [34:0] r;
      logic [69:0] c;
      r = '0;
      for (int b = 34; b >= 0; b--) begin
         c = 70'(r) | (70'd1 << b);
         if (c * c <= 70'(s)) r = c[34:0];
      end
      return r;
   endfunction

   function automatic logic [47:0] link_energy(int c1, int c2, int m);
      logic signed [32:0] d;
      logic [32:0]        ad;
      logic [67:0]        s;
      logic [34:0]        mag, a;
      logic [127:0]       q;
      s = '0;
      for (int k = 0; k < NDIM; k++) begin
         d  = 33'(bead_pos[c1][m][k]) - 33'(bead_pos[c2][m][k]);
         ad = d < 0 ? -d : d;
         s  = s + 68'(66'(ad) * 66'(ad));
      end
      mag = root_q(s);
      a   = mag >= 35'(rest_len) ? mag - 35'(rest_len) : 35'(rest_len) - mag;
      q   = (128'(a) * 128'(a) * 128'(spring_k)) >> 33;
      return q > 128'(ENERGY_SAT) ? ENERGY_SAT : q[47:0];
   endfunction

   function automatic logic [47:0] sections_energy(int lo, int hi);
      logic [48:0] acc;
      acc = '0;
      for (int m = lo; m <= hi; m++)
         for (int b = 0; b < link_cnt[m]; b++) begin
            acc = acc + 49'(link_energy(link_a[m][b], link_b[m][b], m));
            if (acc > 49'(ENERGY_SAT)) acc = 49'(ENERGY_SAT);
         end
      return acc[47:0];
   endfunction

   function automatic energy_word_type predict_energy(bead_op_type op);
      energy_word_type w;
      logic signed [31:0] saved [NDIM];
      logic signed [33:0] t;
      logic [47:0] pre, post;
      int lo, hi;
      w.energy = '0;
      w.status = 1'b0;
      case (op.func)
         FUNC_WRITE: begin
            bead_pos[op.chain][op.section][0] = op.x;
            bead_pos[op.chain][op.section][1] = op.y;
            bead_pos[op.chain][op.section][2] = op.z;
            bead_set[op.chain][op.section] = 1;
         end
         FUNC_LINK: begin
            if (link_cnt[op.section] >= NLNK) w.status = 1'b1;
            else begin
               link_a[op.section][link_cnt[op.section]] = op.chain;
               link_b[op.section][link_cnt[op.section]] = op.partner;
               link_cnt[op.section]++;
            end
         end
         FUNC_CLEAR: link_cnt[op.section] = 0;
         FUNC_DIFF: begin
            lo  = op.section > 0 ? op.section - 1 : 0;
            hi  = op.section < NSEC - 1 ? op.section + 1 : NSEC - 1;
            pre = sections_energy(lo, hi);
            for (int k = 0; k < NDIM; k++) begin
               saved[k] = bead_pos[op.chain][op.section][k];
               t = 34'(saved[k]) + 34'($signed(k == 0 ? op.x : k == 1 ? op.y : op.z));
               if (t > 34'sh7FFFFFFF) t = 34'sh7FFFFFFF;
               if (t < -34'sh80000000) t = -34'sh80000000;
               bead_pos[op.chain][op.section][k] = t[31:0];
            end
            post = sections_energy(lo, hi);
            for (int k = 0; k < NDIM; k++) bead_pos[op.chain][op.section][k] = saved[k];
            w.energy = post - pre;
         end
         FUNC_TOTAL: w.energy = sections_energy(0, NSEC - 1);
         default: ;
      endcase
      return w;
   endfunction

   // Acceptance, prediction and checking all happen on the rising edge.
   always @(posedge clock) begin
      energy_word_type w, got;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            w = predict_energy(cur_op);
            if (cur_op.fixed) begin
               w.energy = cur_op.fixed_energy;
               w.status = cur_op.fixed_status;
            end
            energy_q.push_back(w);
            req_taken++;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SPRING) spring_k = csr_data;
            else if (csr_index == CSR_REST) rest_len = csr_data;
            csr_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.energy = rsp_tdata[47:0];
            got.status = rsp_tdata[48];
            if (energy_q.size() == 0) begin
               $display("%0t: unexpected response word energy=%h status=%b",
                        $time, got.energy, got.status);
               failed = 1;
            end else begin
               w = energy_q.pop_front();
               if (got.energy !== w.energy || got.status !== w.status) begin
                  $display("%0t: mismatch expected energy=%h status=%b, got energy=%h status=%b",
                           $time, w.energy, w.status, got.energy, got.status);
                  failed = 1;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("Simulation FAILED");
            $finish;
         end else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver stalls: stretches, each always-ready or randomly stalled.
   int unsigned stall_left;
   bit          stall_mode;
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_left = $urandom_range(5, 60);
         stall_mode = $urandom_range(0, 2) != 0;
      end
      stall_left--;
      rsp_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
   end

   task automatic send_word(bead_op_type op);
      int unsigned n;
      n = req_taken;
      cur_op     <= op;
      req_tvalid <= 1'b1;
      req_tuser  <= op.func;
      req_tdata  <= {4'b0, op.z, op.y, op.x, op.section, op.partner, op.chain};
      do @(negedge clock); while (req_taken == n);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (energy_q.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [7:0] idx, logic [31:0] val);
      int unsigned n;
      n = csr_taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(negedge clock); while (csr_taken == n);
   endtask

   function automatic bead_op_type mk(logic [2:0] f, logic [2:0] c, logic [2:0] p,
                                      logic [5:0] s, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] z, bit fx = 0,
                                      logic [47:0] fe = '0, logic fs = 1'b0);
      bead_op_type op;
      op.func = f; op.chain = c; op.partner = p; op.section = s;
      op.x = x; op.y = y; op.z = z;
      op.fixed = fx; op.fixed_energy = fe; op.fixed_status = fs;
      return op;
   endfunction

   function automatic logic [31:0] rand_coord();
      if ($urandom_range(0, 1)) return $urandom;
      return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
   endfunction

   function automatic int pick_section();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, NSEC - 1);
      return $urandom_range(0, 1) ? $urandom_range(0, 5) : $urandom_range(58, 63);
   endfunction

   function automatic bead_op_type random_op();
      bead_op_type op;
      int r;
      op = mk(FUNC_WRITE, $urandom_range(0, 7), $urandom_range(0, 7), pick_section(),
              rand_coord(), rand_coord(), rand_coord());
      r = $urandom_range(0, 99);
      if (r < 22) begin
         op.func = FUNC_LINK;
         if (!bead_set[op.chain][op.section] || !bead_set[op.partner][op.section])
            op.func = FUNC_WRITE;
      end else if (r < 28) op.func = FUNC_CLEAR;
      else if (r < 62) begin
         // A trial move needs a bead that has been placed.
         op.func = FUNC_DIFF;
         if (!bead_set[op.chain][op.section]) op.func = FUNC_WRITE;
      end
      else if (r < 64) op.func = FUNC_TOTAL;
      else if (r < 66) op.func = 3'($urandom_range(5, 7));
      return op;
   endfunction

   bead_op_type dir_rows [$];
   logic [31:0] spring_vals [4] = '{32'd0, 32'hFFFF_FFFF, 32'h0002_0000, 32'h0000_3000};
   logic [31:0] rest_vals   [4] = '{32'd0, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0003_0000};

   initial begin
      int unsigned gap;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tuser = '0; req_tdata = '0;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      rsp_tready = 1'b0;
      stall_left = 0; stall_mode = 0;
      req_taken = 0; csr_taken = 0; failed = 0; idle_cycles = 0;
      spring_k = 32'h0001_0000;
      rest_len = 32'h0001_0000;
      foreach (link_cnt[m]) link_cnt[m] = 0;
      foreach (bead_set[c, m]) bead_set[c][m] = 0;
      foreach (bead_pos[c, m, k]) bead_pos[c][m][k] = '0;
      cur_op = mk(FUNC_WRITE, 0, 0, 0, 0, 0, 0);

      dir_rows = '{
         mk(FUNC_WRITE, 0, 0, 0,  32'h0, 32'h0, 32'h0, 1),
         mk(FUNC_WRITE, 1, 0, 0,  32'h0001_0000, 32'h0, 32'h0, 1),
         mk(FUNC_LINK,  0, 1, 0,  32'h0, 32'h0, 32'h0, 1),
         // Link length equals the rest length: no energy at all.
         mk(FUNC_DIFF,  0, 0, 0,  32'h0, 32'h0, 32'h0, 1),
         // Stretching to twice the rest length gives k/2.
         mk(FUNC_DIFF,  1, 0, 0,  32'h0001_0000, 32'h0, 32'h0, 1, 48'h8000),
         mk(FUNC_WRITE, 2, 0, 63, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1),
         mk(FUNC_WRITE, 3, 0, 63, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1),
         mk(FUNC_LINK,  2, 3, 63, 32'h0, 32'h0, 32'h0, 1),
         mk(FUNC_TOTAL, 0, 0, 0,  32'h0, 32'h0, 32'h0, 1, ENERGY_SAT),
         mk(FUNC_LINK,  2, 2, 63, 32'h0, 32'h0, 32'h0, 1),
         mk(FUNC_LINK,  3, 2, 63, 32'h0, 32'h0, 32'h0, 1),
         mk(FUNC_LINK,  3, 2, 63, 32'h0, 32'h0, 32'h0, 1),
         mk(FUNC_LINK,  3, 2, 63, 32'h0, 32'h0, 32'h0, 1),
         mk(FUNC_LINK,  3, 2, 63, 32'h0, 32'h0, 32'h0, 1),
         mk(FUNC_LINK,  3, 2, 63, 32'h0, 32'h0, 32'h0, 1),
         mk(FUNC_LINK,  3, 2, 63, 32'h0, 32'h0, 32'h0, 1),
         // The section table is now full, so this add is dropped.
         mk(FUNC_LINK,  7, 7, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 48'h0, 1'b1),
         mk(FUNC_DIFF,  2, 0, 63, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
         mk(FUNC_DIFF,  3, 0, 63, 32'h7FFF_FFFF, 32'h0, 32'h0),
         mk(FUNC_DIFF,  1, 0, 0,  32'hFFFF_0000, 32'h0, 32'h0),
         mk(FUNC_CLEAR, 0, 0, 63, 32'h0, 32'h0, 32'h0, 1),
         mk(FUNC_TOTAL, 0, 0, 0,  32'h0, 32'h0, 32'h0),
         mk(3'd5, 7, 7, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1),
         mk(3'd6, 0, 0, 0,  32'h0, 32'h0, 32'h0, 1),
         mk(3'd7, 5, 2, 21, 32'h1234_5678, 32'h0, 32'h0, 1)
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) send_word(dir_rows[i]);

      for (int ph = 0; ph < 4; ph++) begin
         // Registers change only with the unit drained.
         wait_drained();
         write_csr(CSR_SPRING, ph == 2 ? $urandom : spring_vals[ph]);
         write_csr(CSR_REST, ph == 2 ? $urandom_range(0, 32'h40000) : rest_vals[ph]);
         csr_valid <= 1'b0;
         for (int i = 0; i < 150; i++) begin
            send_word(random_op());
            if ($urandom_range(0, 3) == 0) begin
               gap = $urandom_range(1, 20);
               req_tvalid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end

      wait_drained();
      repeat (200) @(negedge clock);
      if (!failed && energy_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
